@@ rtl/assert_macros.svh @@
// Assertion shorthands shared by the RTL. Clock and reset names follow the project ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_AT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pidvdt_pkg.sv @@
package pidvdt_pkg;

    localparam int DW            = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DT_W          = 10;
    localparam int QUO_W         = 33;
    localparam int LIM_W         = 31;
    localparam int CFG_IDX_W     = 3;

    localparam logic [DT_W-1:0] DT_DEFAULT = 10'd10;
    localparam logic [DT_W-1:0] DT_CAP     = 10'd1000;
    localparam logic [DT_W-1:0] MS_PER_S   = 10'd1000;

    localparam logic [DW-1:0]    S_MAX    = 32'h7FFF_FFFF;
    localparam logic [DW-1:0]    S_MIN    = 32'h8000_0000;
    localparam logic [LIM_W-1:0] ILIM_RST = 31'd131072;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_SETPOINT  = 3'd3,
        CFG_DRIVE_MIN = 3'd4,
        CFG_DRIVE_MAX = 3'd5,
        CFG_ILIM      = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MUL_P,
        S_MUL_X,
        S_DIV_I,
        S_WAIT_I,
        S_MUL_I,
        S_MUL_D,
        S_SCALE1,
        S_SCALE2,
        S_DIV_D,
        S_WAIT_D,
        S_SUM
    } t_state;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

    // Clamp a two-bit-grown signed value to the data range.
    function automatic logic signed [DW-1:0] sat_dw(input logic signed [DW+1:0] v);
        if (v > $signed({2'b00, S_MAX})) begin
            return S_MAX;
        end
        if (v < $signed({2'b11, S_MIN})) begin
            return S_MIN;
        end
        return v[DW-1:0];
    endfunction

    // Two's complement magnitude; the most negative code maps to 2^(DW-1).
    function automatic logic [DW-1:0] mag_dw(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    // Apply a sign to a magnitude, saturating to the data range.
    function automatic logic signed [DW-1:0] sat_mag(input logic [63:0] m, input logic neg);
        if (neg) begin
            if (m > 64'(S_MIN)) begin
                return S_MIN;
            end
            return ~m[DW-1:0] + 1'b1;
        end
        if (m > 64'(S_MAX)) begin
            return S_MAX;
        end
        return m[DW-1:0];
    endfunction

endpackage

@@ rtl/pidvdt_div.sv @@
module pidvdt_div #(
    parameter int NUM_W = 58,
    parameter int QUO_W = pidvdt_pkg::QUO_W,
    parameter int DEN_W = pidvdt_pkg::DT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output pidvdt_pkg::t_div_stat o_stat,
    output logic [QUO_W-1:0]      o_quo
);

    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CNT_W = $clog2(QUO_W);

    logic             r_run;
    logic             r_done;
    logic             r_ovf;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;

    logic [HI_W-1:0]  w_hi;
    logic             w_ovf;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // quotient would not fit in QUO_W bits when the top part reaches the divisor
    assign w_hi    = i_num[NUM_W-1:QUO_W];
    assign w_ovf   = (w_hi >= HI_W'(i_den));
    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ovf  <= w_ovf;
                r_cnt  <= '0;
                r_run  <= !w_ovf;
                r_done <= w_ovf;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring long division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_hi[DEN_W-1:0];
            r_quo <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_quo       = r_quo;

endmodule

@@ rtl/pid_controller_variable_dt.sv @@
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  --------------------------------------
// in        sink       i_valid / o_ready          i_operation, i_sample, i_stamp_ms
// out       source     o_valid / i_ready          o_drive
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An update beat steps through the sequencer states from accept to o_valid: the pace
// is set by the one-bit-per-cycle divider, run twice when the error is positive and
// once otherwise, plus the shared 33x32 multiplier and the scaling subtracts.
// A clear beat (operation 1) is absorbed in its accept cycle and yields no result.
// o_ready is high only in idle; a finished result sits in the output register while the
// next beat is taken, and the sum stage waits if that register is still full.
// Synchronous active-low reset loads register defaults and empties the controller state.
// o_cfg_ready is always high; config writes are expected while idle.

`include "assert_macros.svh"

module pid_controller_variable_dt #(
    parameter int FRAC_BITS = pidvdt_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input beats
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_operation,
    input  logic signed [pidvdt_pkg::DW-1:0]    i_sample,
    input  logic        [pidvdt_pkg::DW-1:0]    i_stamp_ms,
    // result beats
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [pidvdt_pkg::DW-1:0]    o_drive,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pidvdt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pidvdt_pkg::DW-1:0]           i_cfg_data
);

    localparam int DW     = pidvdt_pkg::DW;
    localparam int DT_W   = pidvdt_pkg::DT_W;
    localparam int QUO_W  = pidvdt_pkg::QUO_W;
    localparam int LIM_W  = pidvdt_pkg::LIM_W;
    localparam int PROD_W = 2 * DW;               // magnitude products stay below 2^63
    localparam int NUMR_W = PROD_W + 7;           // room for product x 126
    localparam int SCL_W  = NUMR_W + 3;           // product x 1000
    localparam int NUM_W  = SCL_W - FRAC_BITS;    // divider numerator

    // configuration registers
    logic signed [DW-1:0]    r_gain_p;
    logic signed [DW-1:0]    r_gain_i;
    logic signed [DW-1:0]    r_gain_d;
    logic signed [DW-1:0]    r_setpoint;
    logic signed [DW-1:0]    r_drive_min;
    logic signed [DW-1:0]    r_drive_max;
    logic [LIM_W-1:0]        r_ilim;

    // sequencer and controller state
    pidvdt_pkg::t_state      r_state;
    pidvdt_pkg::t_state      n_state;
    logic signed [DW-1:0]    r_acc;
    logic signed [DW-1:0]    r_last_err;
    logic [DW-1:0]           r_last_stamp;
    logic                    r_out_valid;

    // per-beat working registers
    logic signed [DW-1:0]    r_sample;
    logic [DW-1:0]           r_stamp;
    logic signed [DW-1:0]    r_err;
    logic [DT_W-1:0]         r_dt;
    logic signed [DW:0]      r_delta;
    logic [PROD_W-1:0]       r_prod;
    logic [NUMR_W-1:0]       r_num;
    logic signed [DW-1:0]    r_p;
    logic signed [DW-1:0]    r_i;
    logic signed [DW-1:0]    r_d;
    logic signed [DW-1:0]    r_drive;

    // sequencer controls
    logic                    w_mul_en;
    logic [DW:0]             w_mul_a;
    logic [DW-1:0]           w_mul_b;
    logic                    w_div_start;
    logic [NUM_W-1:0]        w_div_num;
    logic [DT_W-1:0]         w_div_den;

    // datapath
    logic [PROD_W:0]         w_mul;
    logic [DW:0]             w_delta_mag;
    logic                    w_err_pos;
    logic signed [DW+1:0]    w_err_ext;
    logic [DW-1:0]           w_stamp_diff;
    logic [DT_W-1:0]         w_dt;
    logic signed [DW+1:0]    w_acc_ext;
    logic signed [DW-1:0]    w_acc_sat;
    logic signed [DW-1:0]    w_lim;
    logic signed [DW-1:0]    w_nlim;
    logic signed [DW-1:0]    w_acc_new;
    logic [SCL_W-1:0]        w_scl;
    logic signed [DW+1:0]    w_sum_ext;
    logic signed [DW-1:0]    w_sum_sat;
    logic signed [DW-1:0]    w_drive_new;
    logic [63:0]             w_d_mag;

    pidvdt_pkg::t_div_stat   w_div_stat;
    logic [QUO_W-1:0]        w_div_quo;

    pidvdt_div #(
        .NUM_W (NUM_W),
        .QUO_W (QUO_W),
        .DEN_W (DT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_stat  (w_div_stat),
        .o_quo   (w_div_quo)
    );

    //------------------------------------------------------------------
    // config writes
    //------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_setpoint  <= '0;
            r_drive_min <= pidvdt_pkg::S_MIN;
            r_drive_max <= pidvdt_pkg::S_MAX;
            r_ilim      <= pidvdt_pkg::ILIM_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (pidvdt_pkg::t_cfg_idx'(i_cfg_index))
                pidvdt_pkg::CFG_GAIN_P:    r_gain_p    <= i_cfg_data;
                pidvdt_pkg::CFG_GAIN_I:    r_gain_i    <= i_cfg_data;
                pidvdt_pkg::CFG_GAIN_D:    r_gain_d    <= i_cfg_data;
                pidvdt_pkg::CFG_SETPOINT:  r_setpoint  <= i_cfg_data;
                pidvdt_pkg::CFG_DRIVE_MIN: r_drive_min <= i_cfg_data;
                pidvdt_pkg::CFG_DRIVE_MAX: r_drive_max <= i_cfg_data;
                pidvdt_pkg::CFG_ILIM:      r_ilim      <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // datapath terms
    //------------------------------------------------------------------
    assign w_err_pos   = !r_err[DW-1] && (r_err != '0);
    assign w_delta_mag = r_delta[DW] ? (~r_delta + 1'b1) : r_delta;

    // shared multiplier, unsigned magnitudes; sign is applied afterwards
    assign w_mul = (PROD_W + 1)'(w_mul_a) * (PROD_W + 1)'(w_mul_b);

    // error = sat(sample - setpoint)
    assign w_err_ext = $signed({{2{r_sample[DW-1]}}, r_sample})
                     - $signed({{2{r_setpoint[DW-1]}}, r_setpoint});

    // time step: default when no previous stamp or no elapsed time, capped at one second
    assign w_stamp_diff = r_stamp - r_last_stamp;
    always_comb begin
        if (r_last_stamp == '0 || w_stamp_diff == '0) begin
            w_dt = pidvdt_pkg::DT_DEFAULT;
        end else if (w_stamp_diff > DW'(pidvdt_pkg::DT_CAP)) begin
            w_dt = pidvdt_pkg::DT_CAP;
        end else begin
            w_dt = w_stamp_diff[DT_W-1:0];
        end
    end

    // integral update: add error*dt/1000, saturate, then bound to +/- limit
    assign w_acc_ext = $signed({{2{r_acc[DW-1]}}, r_acc}) + $signed({1'b0, w_div_quo});
    assign w_acc_sat = pidvdt_pkg::sat_dw(w_acc_ext);
    assign w_lim     = $signed({1'b0, r_ilim});
    assign w_nlim    = -w_lim;
    always_comb begin
        if (w_acc_sat > w_lim) begin
            w_acc_new = w_lim;
        end else if (w_acc_sat < w_nlim) begin
            w_acc_new = w_nlim;
        end else begin
            w_acc_new = w_acc_sat;
        end
    end

    // derivative numerator: |kd*delta| * 1000 / 2^frac, later divided by dt
    assign w_scl   = {r_num, 3'b000};
    assign w_d_mag = w_div_stat.ovf ? '1 : 64'(w_div_quo);

    // output: saturated sum, upper clamp first so the lower clamp wins when crossed
    assign w_sum_ext = $signed({{2{r_p[DW-1]}}, r_p}) + $signed({{2{r_i[DW-1]}}, r_i})
                     + $signed({{2{r_d[DW-1]}}, r_d});
    assign w_sum_sat = pidvdt_pkg::sat_dw(w_sum_ext);
    always_comb begin
        w_drive_new = w_sum_sat;
        if (w_drive_new > r_drive_max) begin
            w_drive_new = r_drive_max;
        end
        if (w_drive_new < r_drive_min) begin
            w_drive_new = r_drive_min;
        end
    end

    //------------------------------------------------------------------
    // sequencer: next state
    //------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            pidvdt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = i_operation ? pidvdt_pkg::S_IDLE : pidvdt_pkg::S_ERR;
                end
            end
            pidvdt_pkg::S_ERR:    n_state = pidvdt_pkg::S_MUL_P;
            pidvdt_pkg::S_MUL_P:  n_state = pidvdt_pkg::S_MUL_X;
            pidvdt_pkg::S_MUL_X:  n_state = pidvdt_pkg::S_DIV_I;
            pidvdt_pkg::S_DIV_I: begin
                n_state = w_err_pos ? pidvdt_pkg::S_WAIT_I : pidvdt_pkg::S_MUL_I;
            end
            pidvdt_pkg::S_WAIT_I: begin
                if (w_div_stat.done) begin
                    n_state = pidvdt_pkg::S_MUL_I;
                end
            end
            pidvdt_pkg::S_MUL_I:  n_state = pidvdt_pkg::S_MUL_D;
            pidvdt_pkg::S_MUL_D:  n_state = pidvdt_pkg::S_SCALE1;
            pidvdt_pkg::S_SCALE1: n_state = pidvdt_pkg::S_SCALE2;
            pidvdt_pkg::S_SCALE2: n_state = pidvdt_pkg::S_DIV_D;
            pidvdt_pkg::S_DIV_D:  n_state = pidvdt_pkg::S_WAIT_D;
            pidvdt_pkg::S_WAIT_D: begin
                if (w_div_stat.done) begin
                    n_state = pidvdt_pkg::S_SUM;
                end
            end
            pidvdt_pkg::S_SUM: begin
                if (!r_out_valid || i_ready) begin
                    n_state = pidvdt_pkg::S_IDLE;
                end
            end
            default: n_state = pidvdt_pkg::S_IDLE;
        endcase
    end

    //------------------------------------------------------------------
    // sequencer: controls for the shared units
    //------------------------------------------------------------------
    always_comb begin
        o_ready     = 1'b0;
        w_mul_en    = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_div_num   = NUM_W'(r_prod);
        w_div_den   = pidvdt_pkg::MS_PER_S;
        case (r_state)
            pidvdt_pkg::S_IDLE: o_ready = 1'b1;
            pidvdt_pkg::S_MUL_P: begin
                w_mul_en = 1'b1;
                w_mul_a  = {1'b0, pidvdt_pkg::mag_dw(r_err)};
                w_mul_b  = pidvdt_pkg::mag_dw(r_gain_p);
            end
            pidvdt_pkg::S_MUL_X: begin
                // only consumed when the error is positive
                w_mul_en = 1'b1;
                w_mul_a  = {1'b0, r_err};
                w_mul_b  = DW'(r_dt);
            end
            pidvdt_pkg::S_DIV_I: begin
                w_div_start = w_err_pos;
            end
            pidvdt_pkg::S_MUL_I: begin
                w_mul_en = 1'b1;
                w_mul_a  = {1'b0, pidvdt_pkg::mag_dw(r_acc)};
                w_mul_b  = pidvdt_pkg::mag_dw(r_gain_i);
            end
            pidvdt_pkg::S_MUL_D: begin
                w_mul_en = 1'b1;
                w_mul_a  = w_delta_mag;
                w_mul_b  = pidvdt_pkg::mag_dw(r_gain_d);
            end
            pidvdt_pkg::S_DIV_D: begin
                w_div_start = 1'b1;
                w_div_num   = NUM_W'(w_scl >> FRAC_BITS);
                w_div_den   = r_dt;
            end
            default: ;
        endcase
    end

    //------------------------------------------------------------------
    // control and controller state
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pidvdt_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_acc        <= '0;
            r_last_err   <= '0;
            r_last_stamp <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                pidvdt_pkg::S_IDLE: begin
                    if (i_valid && i_operation) begin
                        r_acc        <= '0;
                        r_last_err   <= '0;
                        r_last_stamp <= '0;
                    end
                end
                pidvdt_pkg::S_ERR: begin
                    r_last_stamp <= r_stamp;
                end
                pidvdt_pkg::S_MUL_P: begin
                    r_last_err <= r_err;
                end
                pidvdt_pkg::S_DIV_I: begin
                    if (!w_err_pos) begin
                        r_acc <= '0;
                    end
                end
                pidvdt_pkg::S_WAIT_I: begin
                    if (w_div_stat.done) begin
                        r_acc <= w_acc_new;
                    end
                end
                pidvdt_pkg::S_SUM: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // working registers
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul[PROD_W-1:0];
        end
        case (r_state)
            pidvdt_pkg::S_IDLE: begin
                if (i_valid) begin
                    r_sample <= i_sample;
                    r_stamp  <= i_stamp_ms;
                end
            end
            pidvdt_pkg::S_ERR: begin
                r_err <= pidvdt_pkg::sat_dw(w_err_ext);
                r_dt  <= w_dt;
            end
            pidvdt_pkg::S_MUL_P: begin
                r_delta <= $signed({r_err[DW-1], r_err}) - $signed({r_last_err[DW-1], r_last_err});
            end
            pidvdt_pkg::S_MUL_X: begin
                r_p <= pidvdt_pkg::sat_mag(r_prod >> FRAC_BITS, r_gain_p[DW-1] ^ r_err[DW-1]);
            end
            pidvdt_pkg::S_MUL_D: begin
                r_i <= pidvdt_pkg::sat_mag(r_prod >> FRAC_BITS, r_gain_i[DW-1] ^ r_acc[DW-1]);
            end
            pidvdt_pkg::S_SCALE1: begin
                // x126 now, minus one more copy next cycle gives x125; x8 is the final shift
                r_num <= (NUMR_W'(r_prod) << 7) - (NUMR_W'(r_prod) << 1);
            end
            pidvdt_pkg::S_SCALE2: begin
                r_num <= r_num - NUMR_W'(r_prod);
            end
            pidvdt_pkg::S_WAIT_D: begin
                if (w_div_stat.done) begin
                    r_d <= pidvdt_pkg::sat_mag(w_d_mag, r_gain_d[DW-1] ^ r_delta[DW]);
                end
            end
            pidvdt_pkg::S_SUM: begin
                if (!r_out_valid || i_ready) begin
                    r_drive <= w_drive_new;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

    //------------------------------------------------------------------
    // checks
    //------------------------------------------------------------------
    `ASSERT_AT(a_dt_range, (r_state != pidvdt_pkg::S_IDLE) && (r_state != pidvdt_pkg::S_ERR), (r_dt != '0) && (r_dt <= pidvdt_pkg::DT_CAP), "time step out of range")

    `ASSERT_AT(a_div_done_wait, w_div_stat.done, (r_state == pidvdt_pkg::S_WAIT_I) || (r_state == pidvdt_pkg::S_WAIT_D), "divider finished outside a wait state")

    `ASSERT_AT(a_valid_from_sum, $rose(o_valid), $past(r_state) == pidvdt_pkg::S_SUM, "result raised outside the sum stage")

    `ASSERT_NEXT(a_clear_empties, (r_state == pidvdt_pkg::S_IDLE) && i_valid && i_operation, (r_acc == '0) && (r_last_err == '0) && (r_last_stamp == '0), "clear beat left state behind")

endmodule

@@ tb/pid_tb_pkg.sv @@
`timescale 1ns / 100ps

package pid_tb_pkg;

    // Operation field of an input beat.
    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_pid_op;

endpackage

@@ tb/pid_drive_checker.sv @@
`timescale 1ns / 100ps

module pid_drive_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic                             i_operation,
    input  logic signed [pidvdt_pkg::DW-1:0] i_sample,
    input  logic        [pidvdt_pkg::DW-1:0] i_stamp_ms,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic signed [pidvdt_pkg::DW-1:0] i_drive,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [pidvdt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [pidvdt_pkg::DW-1:0] i_cfg_data,
    output int                               o_mismatches,
    output int                               o_outstanding
);
    import pidvdt_pkg::*;
    import pid_tb_pkg::*;

    localparam int     FRAC           = FRAC_BITS_DEF;
    localparam longint DRIVE_TOP      = 64'sh0000_0000_7FFF_FFFF;
    localparam longint DRIVE_BOTTOM   = -64'sh0000_0000_8000_0000;
    localparam longint DT_FALLBACK_MS = 10;
    localparam longint DT_LIMIT_MS    = 1000;
    localparam longint MS_PER_SEC     = 1000;
    localparam longint unsigned WORD_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam int     MAX_REPORTS    = 200;

    // register copies
    longint kp, ki, kd, target, drive_lo, drive_hi, integ_bound;
    // controller history
    longint            integ_acc;
    longint            prev_err;
    logic [DW-1:0]     prev_stamp;

    logic signed [DW-1:0] drive_expected[$];
    int                   mism = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic longint saturate_word(longint v);
        if (v > DRIVE_TOP) begin
            return DRIVE_TOP;
        end
        if (v < DRIVE_BOTTOM) begin
            return DRIVE_BOTTOM;
        end
        return v;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic longint apply_sign(longint unsigned m, bit neg);
        longint unsigned cap;
        cap = neg ? $unsigned(-DRIVE_BOTTOM) : $unsigned(DRIVE_TOP);
        if (m > cap) begin
            m = cap;
        end
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // a * b scaled down by the fraction bits, truncated toward zero
    function automatic longint frac_product(longint a, longint b);
        longint unsigned m;
        m = magnitude(a) * magnitude(b);
        return apply_sign(m >> FRAC, (a < 0) != (b < 0));
    endfunction

    function automatic void forget_history();
        integ_acc  = 0;
        prev_err   = 0;
        prev_stamp = '0;
    endfunction

    function automatic logic signed [DW-1:0] predict_drive(logic signed [DW-1:0] smp,
                                                           logic [DW-1:0] stamp);
        longint          s, err, dt, pterm, iterm, dterm, delta, total;
        longint unsigned q, den, t, r, a;
        logic [DW-1:0]   span;
        s   = smp;
        err = saturate_word(s - target);

        dt = DT_FALLBACK_MS;
        if (prev_stamp != '0) begin
            span = stamp - prev_stamp;
            dt   = span;
            if (dt == 0) begin
                dt = DT_FALLBACK_MS;
            end
            if (dt > DT_LIMIT_MS) begin
                dt = DT_LIMIT_MS;
            end
        end
        prev_stamp = stamp;

        pterm = frac_product(kp, err);

        // one-sided integral: only a positive error accumulates
        if (err > 0) begin
            integ_acc = saturate_word(integ_acc + (err * dt) / MS_PER_SEC);
        end else begin
            integ_acc = 0;
        end
        if (integ_acc > integ_bound) begin
            integ_acc = integ_bound;
        end
        if (integ_acc < -integ_bound) begin
            integ_acc = -integ_bound;
        end
        iterm = frac_product(ki, integ_acc);

        // kd * delta * 1000 / (dt << FRAC), split to keep within 64 bits
        delta = err - prev_err;
        q     = magnitude(kd) * magnitude(delta);
        den   = dt << FRAC;
        t     = q / den;
        r     = q % den;
        if (t > WORD_MAX) begin
            a = '1;
        end else begin
            a = t * MS_PER_SEC + (r * MS_PER_SEC) / den;
        end
        dterm    = apply_sign(a, (kd < 0) != (delta < 0));
        prev_err = err;

        total = saturate_word(pterm + iterm + dterm);
        if (total > drive_hi) begin
            total = drive_hi;
        end
        if (total < drive_lo) begin
            total = drive_lo;
        end
        return total[DW-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic signed [DW-1:0] want;
        if (!i_rst_n) begin
            kp          = 0;
            ki          = 0;
            kd          = 0;
            target      = 0;
            drive_lo    = DRIVE_BOTTOM;
            drive_hi    = DRIVE_TOP;
            integ_bound = ILIM_RST;
            forget_history();
            drive_expected.delete();
        end else begin
            // results first, so a beat taken in the same cycle is not matched early
            if (i_out_valid && i_out_ready) begin
                if (drive_expected.size() == 0) begin
                    mism++;
                    if (mism <= MAX_REPORTS) begin
                        $error("drive: expected none, actual %0d", i_drive);
                    end
                end else begin
                    want = drive_expected.pop_front();
                    if (i_drive !== want) begin
                        mism++;
                        if (mism <= MAX_REPORTS) begin
                            $error("drive: expected %0d, actual %0d", want, i_drive);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GAIN_P:    kp          = $signed(i_cfg_data);
                    CFG_GAIN_I:    ki          = $signed(i_cfg_data);
                    CFG_GAIN_D:    kd          = $signed(i_cfg_data);
                    CFG_SETPOINT:  target      = $signed(i_cfg_data);
                    CFG_DRIVE_MIN: drive_lo    = $signed(i_cfg_data);
                    CFG_DRIVE_MAX: drive_hi    = $signed(i_cfg_data);
                    CFG_ILIM:      integ_bound = i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (t_pid_op'(i_operation) == OP_CLEAR) begin
                    forget_history();
                end else begin
                    drive_expected.push_back(predict_drive(i_sample, i_stamp_ms));
                end
            end
        end
        o_mismatches  <= mism;
        o_outstanding <= drive_expected.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import pidvdt_pkg::*;
    import pid_tb_pkg::*;

    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 120;
    // slowest run is roughly 1500 beats of busy time, send gap and result stall
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 100;
    localparam int CALM_STRETCH    = 40;

    // index past the last register; the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // a few Q16.16 levels
    localparam logic [DW-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [DW-1:0] Q_HALF = 32'h0000_8000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel
    logic          in_valid     = 1'b0;
    logic          in_ready;
    logic          in_operation = OP_UPDATE;
    logic [DW-1:0] in_sample    = '0;
    logic [DW-1:0] in_stamp     = '0;
    // result channel
    logic          out_valid;
    logic          out_ready    = 1'b0;
    logic [DW-1:0] out_drive;
    // register writes
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DW-1:0]        cfg_data  = '0;

    int mismatches;
    int outstanding;
    int cycles = 0;

    // stimulus state
    logic [DW-1:0] target   = '0;
    logic [DW-1:0] clock_ms = '0;
    bit            tx_calm  = 1'b0;
    bit            rx_calm  = 1'b0;
    int            tx_count = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pid_controller_variable_dt dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_operation (in_operation),
        .i_sample    (in_sample),
        .i_stamp_ms  (in_stamp),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_drive     (out_drive),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pid_drive_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_operation   (in_operation),
        .i_sample      (in_sample),
        .i_stamp_ms    (in_stamp),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_drive       (out_drive),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // One input beat. The gap before it is drawn per beat; valid stays high
    // across back-to-back beats, only the payload moves.
    task automatic send_item(input t_pid_op op, input logic [DW-1:0] smp,
                             input logic [DW-1:0] stamp);
        int gap;
        if (tx_count % CALM_STRETCH == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
        end
        tx_count++;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_operation <= op;
        in_sample    <= smp;
        in_stamp     <= stamp;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Stop sending and let every pending result come out. The first edge is
    // taken unconditionally so a beat accepted on this edge is counted.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        // a trailing clear beat yields nothing; give the block idle time to settle
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_all(input logic [DW-1:0] gp, input logic [DW-1:0] gi,
                               input logic [DW-1:0] gd, input logic [DW-1:0] sp,
                               input logic [DW-1:0] lo, input logic [DW-1:0] hi,
                               input logic [DW-1:0] bound);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_SETPOINT, sp);
        write_reg(CFG_DRIVE_MIN, lo);
        write_reg(CFG_DRIVE_MAX, hi);
        write_reg(CFG_ILIM, bound);
        target = sp;
    endtask

    // Gains: mostly moderate so the three terms stay comparable, some extremes.
    function automatic logic [DW-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return S_MAX;
        end else if (r == 2) begin
            return S_MIN;
        end else if (r <= 5) begin
            return $urandom();
        end else if (r <= 11) begin
            return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        end
        return $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
    endfunction

    // Setpoints and clamp levels.
    function automatic logic [DW-1:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5) begin
            return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        end else if (r <= 7) begin
            return $urandom();
        end else if (r == 8) begin
            return S_MAX;
        end
        return S_MIN;
    endfunction

    // Samples sit near the setpoint so the error changes sign often and the
    // integral both builds up and gets cleared.
    function automatic logic [DW-1:0] pick_sample(input logic [DW-1:0] sp);
        int r;
        r = $urandom_range(0, 19);
        if (r <= 11) begin
            return sp + ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
        end else if (r == 12) begin
            return sp;
        end else if (r <= 14) begin
            return sp + ($urandom_range(0, 32) - 16);
        end else if (r <= 16) begin
            return $urandom();
        end else if (r == 17) begin
            return S_MAX;
        end else if (r == 18) begin
            return S_MIN;
        end
        return sp + 1;
    endfunction

    // Time stamps: mostly a clock that moves forward by sane steps, with
    // repeats, missing stamps, long gaps, jumps back and wraps mixed in.
    function automatic logic [DW-1:0] next_stamp();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            12, 13:  clock_ms += $urandom_range(201, 3000);
            14:      ;
            15:      return '0;
            16:      clock_ms -= $urandom_range(1, 100);
            17:      clock_ms = $urandom();
            18:      clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
            19:      clock_ms += $urandom_range(1, 20);
            default: clock_ms += $urandom_range(1, 200);
        endcase
        return clock_ms;
    endfunction

    // Result side: stalls drawn per beat, with calm stretches of no stall.
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken % CALM_STRETCH == 0) begin
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            taken++;
            gap = rx_calm ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Watchdog.
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        logic [DW-1:0] ki;
        logic [DW-1:0] lo;
        logic [DW-1:0] hi;
        logic [DW-1:0] swap;
        logic [DW-1:0] bound;
        longint        ki_mag;
        longint        quota;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults straight out of reset: zero gains give a zero drive.
        send_item(OP_UPDATE, 32'h0003_0000, 32'd50);
        wait_for_results();

        // --- directed: moderate gains, setpoint 1.0, clamps at +/-100.0 ---
        program_all(Q_ONE, Q_HALF, 32'h0000_4000, Q_ONE,
                    32'hFF9C_0000, 32'h0064_0000, 32'h0004_0000);
        // stamp 0 after 50 is capped at one second; a stored zero then gives 10 ms
        send_item(OP_UPDATE, 32'h0002_0000, 32'd0);
        send_item(OP_UPDATE, 32'h0003_0000, 32'd0);
        send_item(OP_UPDATE, 32'h0003_8000, 32'd100);
        // same stamp twice: zero step falls back to 10 ms
        send_item(OP_UPDATE, 32'h0003_8000, 32'd100);
        // long gap is capped at one second
        send_item(OP_UPDATE, 32'h0004_0000, 32'd5000);
        send_item(OP_UPDATE, 32'h0002_0000, 32'd5500);
        // error exactly zero clears the integral
        send_item(OP_UPDATE, Q_ONE, 32'd5600);
        // negative error, then a stamp that wraps through zero
        send_item(OP_UPDATE, 32'hFFFD_0000, 32'hFFFF_FFF0);
        send_item(OP_UPDATE, 32'h0002_0000, 32'h0000_0005);
        // sample extremes: error saturates, error step spans the full range
        send_item(OP_UPDATE, S_MAX, 32'd6);
        send_item(OP_UPDATE, S_MIN, 32'd7);
        send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_UPDATE, 32'h0001_8000, 32'd20);
        // drive pinned to the upper and then the lower clamp
        send_item(OP_UPDATE, 32'h00C8_0000, 32'd40);
        send_item(OP_UPDATE, 32'hFF38_0000, 32'd60);
        wait_for_results();

        // --- directed: largest positive gains, lowest setpoint, widest limits ---
        program_all(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MAX, 32'h7FFF_FFFF);
        send_item(OP_UPDATE, S_MAX, 32'd1);
        send_item(OP_UPDATE, S_MIN, 32'd2);
        send_item(OP_UPDATE, 32'h0000_0000, 32'd3);
        send_item(OP_UPDATE, S_MAX, 32'd3);
        wait_for_results();

        // --- directed: most negative gains, highest setpoint, crossed clamps,
        //     zero integral bound; the unused index must change nothing ---
        program_all(S_MIN, S_MIN, S_MIN, S_MAX, 32'h03E8_0000, 32'hFC18_0000, 32'h0000_0000);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_UPDATE, S_MIN, 32'd1);
        send_item(OP_UPDATE, S_MAX, 32'd1001);
        send_item(OP_CLEAR, 32'h0000_0000, 32'h0000_0000);
        send_item(OP_UPDATE, 32'h0000_0000, 32'd4);

        // --- random phases, each with fresh register settings ---
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_for_results();
            ki = pick_gain();
            lo = pick_level();
            hi = pick_level();
            // usually ordered clamps, sometimes crossed, sometimes wide open
            if ($urandom_range(0, 9) < 7 && $signed(lo) > $signed(hi)) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            if ($urandom_range(0, 6) == 0) begin
                lo = S_MIN;
                hi = S_MAX;
            end
            // integral bound as software sets it: 2/ki in Q16.16, 2.0 for ki zero
            ki_mag = $signed(ki);
            if (ki_mag < 0) begin
                ki_mag = -ki_mag;
            end
            if (ki_mag == 0) begin
                bound = ILIM_RST;
            end else begin
                quota = (64'sd1 <<< 33) / ki_mag;
                bound = (quota > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF : quota[DW-1:0];
            end
            if ($urandom_range(0, 4) == 0) begin
                bound = $urandom();
            end
            // top bit is outside the register and must be dropped
            if ($urandom_range(0, 3) == 0) begin
                bound[DW-1] = 1'b1;
            end
            program_all(pick_gain(), ki, pick_gain(), pick_level(), lo, hi, bound);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // now and then hold off until the block has drained
                if ($urandom_range(0, 99) == 0) begin
                    wait_for_results();
                end
                if ($urandom_range(0, 31) == 0) begin
                    send_item(OP_CLEAR, $urandom(), $urandom());
                end else begin
                    send_item(OP_UPDATE, pick_sample(target), next_stamp());
                end
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
